/* rtl/mau_pkg.sv */
package mau_pkg;

	localparam int WORD_BITS = 30;
	localparam int EXP_BITS  = 63;
	localparam int CMD_BITS  = 4;
	localparam int CNT_W     = $clog2(WORD_BITS);

	localparam logic [WORD_BITS-1:0] MOD_RESET = WORD_BITS'(998244353);

	localparam logic [CMD_BITS-1:0] CMD_ADD  = 4'd0;
	localparam logic [CMD_BITS-1:0] CMD_SUB  = 4'd1;
	localparam logic [CMD_BITS-1:0] CMD_NEG  = 4'd2;
	localparam logic [CMD_BITS-1:0] CMD_MUL  = 4'd3;
	localparam logic [CMD_BITS-1:0] CMD_DIV  = 4'd4;
	localparam logic [CMD_BITS-1:0] CMD_POW  = 4'd5;
	localparam logic [CMD_BITS-1:0] CMD_INV  = 4'd6;
	localparam logic [CMD_BITS-1:0] CMD_LESS = 4'd7;
	localparam logic [CMD_BITS-1:0] CMD_EQ   = 4'd8;

	typedef struct packed {
		logic [CMD_BITS-1:0]  command;
		logic [WORD_BITS-1:0] operand_a;
		logic [WORD_BITS-1:0] operand_b;
		logic [EXP_BITS-1:0]  exponent;
	} req_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] result_value;
		logic                 compare_flag;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_EXEC,
		ST_PSTEP,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		JOB_RMUL,
		JOB_SQR,
		JOB_FINAL
	} job_t;

endpackage

/* rtl/modular_arithmetic_unit_core.sv */
// Modular arithmetic unit over a prime modulus held in a 30-bit register
// (reset 998244353), written through cfg_wr_en/cfg_wr_data; the user must
// write it only while the unit is idle, and the block does not enforce this.
// Each request transaction carries a command (add, sub, neg, mul, div,
// pow, inv, less, equal), two operands and a 63-bit exponent; exactly one
// response transaction comes back. Everything is bit serial: both operands
// are first reduced modulo the modulus, one bit per cycle; a modular
// multiply is an interleaved shift-and-add over the 30 multiplier bits.
// Add, sub, neg and the compares then finish directly on the residues. Pow
// scans the exponent from its low end, one square per exponent bit plus one
// multiply per set bit, stopping after the highest set bit. Inv is pow with
// exponent modulus-2 and div is inv followed by one multiply. Division or
// inversion of zero returns 0, and a modulus of zero returns 0 for every
// command. A new request is taken as soon as the previous result has moved
// into the output register, even if that result is still stalled.
module modular_arithmetic_unit_core
	import mau_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [WORD_BITS-1:0] cfg_wr_data,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp_data
);

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

	state_t state_q, state_d;

	// configuration
	logic [WORD_BITS-1:0] mod_q;

	// request payload, residues and command
	logic [WORD_BITS-1:0] ain_q, bin_q;   // raw operands, shifted out msb first
	logic [WORD_BITS-1:0] a_q, b_q;       // reduced residues
	logic [CMD_BITS-1:0]  cmd_q;
	logic [EXP_BITS-1:0]  k_q;            // exponent, shifted right per square
	logic                 div_q;          // pow result feeds a final multiply

	// serial multiplier
	logic [WORD_BITS-1:0] mx_q, my_q, macc_q;
	logic [CNT_W-1:0]     mcnt_q;
	job_t                 job_q;

	// power accumulator and base
	logic [WORD_BITS-1:0] pr_q, pt_q;

	// result and output register
	logic [WORD_BITS-1:0] res_q;
	logic                 flag_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_data_q;

	logic cnt_last, out_free, mod_zero, mod_lt2, mod_one;

	assign cnt_last = (mcnt_q == CNT_LAST);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign mod_zero = (mod_q == '0);
	assign mod_one  = (mod_q == WORD_BITS'(1));
	assign mod_lt2  = mod_zero || mod_one;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	// ---------------------------------------------------------------
	// Reduction step: r = 2r + next bit, minus m once if it overflows.
	// ---------------------------------------------------------------
	logic [WORD_BITS:0]   m_ext;
	logic [WORD_BITS:0]   ta, tb, da, db;
	logic [WORD_BITS-1:0] red_a, red_b;

	assign m_ext = {1'b0, mod_q};
	assign ta    = {a_q, ain_q[WORD_BITS-1]};
	assign tb    = {b_q, bin_q[WORD_BITS-1]};
	assign da    = ta - m_ext;
	assign db    = tb - m_ext;
	assign red_a = (ta >= m_ext) ? da[WORD_BITS-1:0] : ta[WORD_BITS-1:0];
	assign red_b = (tb >= m_ext) ? db[WORD_BITS-1:0] : tb[WORD_BITS-1:0];

	// ---------------------------------------------------------------
	// Multiply step: acc = 2*acc + bit*x, which stays below 3m, then
	// subtract 0, m or 2m.
	// ---------------------------------------------------------------
	logic [WORD_BITS+1:0] mt, mt_m1, mt_m2, m1_w, m2_w;
	logic [WORD_BITS-1:0] mul_next;

	assign m1_w  = {2'b00, mod_q};
	assign m2_w  = {1'b0, mod_q, 1'b0};
	assign mt    = {1'b0, macc_q, 1'b0}
	             + {2'b00, (my_q[WORD_BITS-1] ? mx_q : {WORD_BITS{1'b0}})};
	assign mt_m1 = mt - m1_w;
	assign mt_m2 = mt - m2_w;
	assign mul_next = (mt >= m2_w) ? mt_m2[WORD_BITS-1:0] :
	                  (mt >= m1_w) ? mt_m1[WORD_BITS-1:0] : mt[WORD_BITS-1:0];

	// ---------------------------------------------------------------
	// Add, sub and neg computed combinationally on the residues.
	// ---------------------------------------------------------------
	logic [WORD_BITS:0]   add_s, add_d, sub_w;
	logic [WORD_BITS-1:0] add_r, sub_r, neg_r;

	assign add_s = {1'b0, a_q} + {1'b0, b_q};
	assign add_d = add_s - m_ext;
	assign add_r = (add_s >= m_ext) ? add_d[WORD_BITS-1:0] : add_s[WORD_BITS-1:0];
	assign sub_w = {1'b0, a_q} + m_ext - {1'b0, b_q};
	assign sub_r = (a_q >= b_q) ? (a_q - b_q) : sub_w[WORD_BITS-1:0];
	assign neg_r = (a_q == '0) ? '0 : (mod_q - a_q);

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = mod_zero ? ST_DONE : ST_RED;
				end
			end
			ST_RED: begin
				if (cnt_last) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (cmd_q)
					CMD_MUL: state_d = ST_MUL;
					CMD_POW: state_d = ST_PSTEP;
					CMD_INV: state_d = (a_q == '0 || mod_lt2) ? ST_DONE : ST_PSTEP;
					CMD_DIV: state_d = (b_q == '0 || mod_lt2) ? ST_DONE : ST_PSTEP;
					default: state_d = ST_DONE;
				endcase
			end
			ST_PSTEP: begin
				if (k_q == '0) begin
					state_d = div_q ? ST_MUL : ST_DONE;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (cnt_last && job_q == JOB_SQR) begin
					state_d = ST_PSTEP;
				end else if (cnt_last && job_q == JOB_FINAL) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q       <= MOD_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mod_q <= cfg_wr_data;
			end
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					ain_q  <= req_data.operand_a;
					bin_q  <= req_data.operand_b;
					cmd_q  <= req_data.command;
					k_q    <= req_data.exponent;
					a_q    <= '0;
					b_q    <= '0;
					mcnt_q <= '0;
					res_q  <= '0;
					flag_q <= 1'b0;
					div_q  <= 1'b0;
				end
			end
			ST_RED: begin
				a_q    <= red_a;
				b_q    <= red_b;
				ain_q  <= ain_q << 1;
				bin_q  <= bin_q << 1;
				mcnt_q <= cnt_last ? '0 : mcnt_q + CNT_W'(1);
			end
			ST_EXEC: begin
				unique case (cmd_q)
					CMD_ADD: res_q <= add_r;
					CMD_SUB: res_q <= sub_r;
					CMD_NEG: res_q <= neg_r;
					CMD_MUL: begin
						mx_q   <= a_q;
						my_q   <= b_q;
						macc_q <= '0;
						job_q  <= JOB_FINAL;
					end
					CMD_DIV: begin
						div_q <= 1'b1;
						pt_q  <= b_q;
						pr_q  <= WORD_BITS'(1);
						k_q   <= {{(EXP_BITS-WORD_BITS){1'b0}}, mod_q - WORD_BITS'(2)};
					end
					CMD_INV: begin
						pt_q <= a_q;
						pr_q <= WORD_BITS'(1);
						k_q  <= {{(EXP_BITS-WORD_BITS){1'b0}}, mod_q - WORD_BITS'(2)};
					end
					CMD_POW: begin
						pt_q <= a_q;
						pr_q <= mod_one ? '0 : WORD_BITS'(1);
					end
					CMD_LESS: flag_q <= (a_q < b_q);
					CMD_EQ:   flag_q <= (a_q == b_q);
					default: ;
				endcase
			end
			ST_PSTEP: begin
				macc_q <= '0;
				mcnt_q <= '0;
				if (k_q == '0) begin
					if (div_q) begin
						mx_q  <= a_q;
						my_q  <= pr_q;
						job_q <= JOB_FINAL;
					end else begin
						res_q <= pr_q;
					end
				end else if (k_q[0]) begin
					mx_q  <= pr_q;
					my_q  <= pt_q;
					job_q <= JOB_RMUL;
				end else begin
					mx_q  <= pt_q;
					my_q  <= pt_q;
					job_q <= JOB_SQR;
				end
			end
			ST_MUL: begin
				mcnt_q <= cnt_last ? '0 : mcnt_q + CNT_W'(1);
				if (cnt_last && job_q == JOB_RMUL) begin
					// multiply done, square of the base follows
					pr_q   <= mul_next;
					mx_q   <= pt_q;
					my_q   <= pt_q;
					macc_q <= '0;
					job_q  <= JOB_SQR;
				end else begin
					macc_q <= mul_next;
					my_q   <= my_q << 1;
					if (cnt_last) begin
						unique case (job_q)
							JOB_SQR: begin
								pt_q <= mul_next;
								k_q  <= k_q >> 1;
							end
							JOB_FINAL: res_q <= mul_next;
							default: ;
						endcase
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					rsp_data_q.result_value <= res_q;
					rsp_data_q.compare_flag <= flag_q;
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_req_start: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == ST_RED || state_q == ST_DONE))
		else $error("request not followed by reduction or done");

	a_red_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RED) |-> (a_q < mod_q && b_q < mod_q))
		else $error("partial remainder not below modulus");

	a_pow_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PSTEP) |-> (pr_q < mod_q && pt_q < mod_q))
		else $error("power registers not reduced");

	a_mul_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (macc_q < mod_q && mcnt_q <= CNT_LAST))
		else $error("multiplier accumulator or count out of range");

	a_done_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && flag_q) |-> (res_q == '0))
		else $error("compare result with nonzero value");
`endif

endmodule
